// File: src/utb_pkg.sv
// Shared types and constants for the transmit ring buffer.
// No dependencies; imported by utb_ring_mem and uart_tx_ring_buffer.
`default_nettype none

package utb_pkg;

    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 13;
    localparam int PEND_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 40;

    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam action_t ACT_PUSH     = 2'd0;
    localparam action_t ACT_TX_READY = 2'd1;
    localparam action_t ACT_CLEAR    = 2'd2;

    localparam cfg_idx_t CFG_BUFFER_LENGTH = 1'b0;
    localparam cfg_idx_t CFG_RS485_MODE    = 1'b1;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic              tx_request;
        logic              line_drive;
        logic              send_done;
        logic [LEN_W-1:0]  free_count;
        logic [PEND_W-1:0] pending_count;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic              accepted;
    } result_t;

endpackage

`default_nettype wire

// File: src/uart_tx_ring_buffer.sv
// Transmit ring buffer with one slot kept empty, top level.
// A taken input transaction passes the input register, then the result
// register, before its result leaves. Throughput: one item per cycle unless
// m_tready stalls the output; the ring indices are updated once per item and
// the byte store has one read and one write port. Synchronous active-low reset
// clears the indices, the drive and request flags and both configuration registers.
// Depends on utb_pkg and utb_ring_mem.
`default_nettype none

module uart_tx_ring_buffer
    import utb_pkg::*;
#(
    parameter int BUF_DEPTH = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input items.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [ACTION_W-1:0]  s_tuser,   // [1:0] action
    // Results.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] accepted, [1] tx_valid, [9:2] tx_byte, [21:10] pending_count,
    // [34:22] free_count, [35] send_done, [36] line_drive, [37] tx_request,
    // [39:38] zero
    output logic      [M_DATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    localparam int IDX_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int WIDE_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

    // Pipeline registers.
    logic              in_valid_reg;
    action_t           in_action_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_ready;
    logic              fire;

    // Ring state and configuration.
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             drive_reg, drive_next;
    logic             req_reg, req_next;
    logic [LEN_W-1:0] len_reg;
    logic             mode_reg;

    logic [WIDE_W-1:0] len_w;
    logic [WIDE_W-1:0] wr_inc, rd_inc;
    logic [IDX_W-1:0]  wr_wrap, rd_wrap;
    logic [WIDE_W-1:0] pend;
    logic              mem_wr_en;
    logic [BYTE_W-1:0] head_byte;
    logic              cfg_fire;
    result_t           res;
    result_t           res_out;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign len_w   = WIDE_W'(len_reg);
    assign wr_inc  = WIDE_W'(wr_idx_reg) + WIDE_W'(1);
    assign rd_inc  = WIDE_W'(rd_idx_reg) + WIDE_W'(1);
    assign wr_wrap = (wr_inc >= len_w) ? '0 : wr_inc[IDX_W-1:0];
    assign rd_wrap = (rd_inc >= len_w) ? '0 : rd_inc[IDX_W-1:0];

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        drive_next  = drive_reg;
        req_next    = req_reg;
        mem_wr_en   = 1'b0;
        res         = '0;
        if (fire) begin
            unique case (in_action_reg)
                ACT_PUSH: begin
                    if (len_reg != '0) begin
                        if (wr_wrap != rd_idx_reg) begin
                            mem_wr_en    = 1'b1;
                            wr_idx_next  = wr_wrap;
                            res.accepted = 1'b1;
                        end
                        req_next = 1'b1;
                    end
                end
                ACT_TX_READY: begin
                    if (wr_idx_reg == rd_idx_reg) begin
                        req_next = 1'b0;
                    end else begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = head_byte;
                        rd_idx_next  = rd_wrap;
                        if (mode_reg) begin
                            drive_next = 1'b1;
                        end
                        // The ring just drained: release the line and stop asking.
                        if (wr_idx_reg == rd_wrap) begin
                            if (mode_reg) begin
                                drive_next = 1'b0;
                            end
                            req_next      = 1'b0;
                            res.send_done = 1'b1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    if (len_reg != '0) begin
                        wr_idx_next = '0;
                        rd_idx_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (cfg_fire && (cfg_index == CFG_BUFFER_LENGTH)) begin
            wr_idx_next = '0;
            rd_idx_next = '0;
        end
    end

    always_comb begin
        if (rd_idx_next <= wr_idx_next) begin
            pend = WIDE_W'(wr_idx_next) - WIDE_W'(rd_idx_next);
        end else begin
            pend = len_w + WIDE_W'(wr_idx_next) - WIDE_W'(rd_idx_next);
        end
    end

    always_comb begin
        res_out               = res;
        res_out.pending_count = pend[PEND_W-1:0];
        res_out.free_count    = len_reg - pend[LEN_W-1:0];
        res_out.line_drive    = drive_next;
        res_out.tx_request    = req_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            drive_reg     <= 1'b0;
            req_reg       <= 1'b0;
            len_reg       <= '0;
            mode_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            drive_reg  <= drive_next;
            req_reg    <= req_next;
            if (cfg_fire) begin
                unique case (cfg_index)
                    CFG_BUFFER_LENGTH: begin
                        len_reg <= (32'(cfg_data) > 32'(BUF_DEPTH)) ? '0 : cfg_data;
                    end
                    CFG_RS485_MODE: begin
                        mode_reg <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_action_reg <= s_tuser;
            in_data_reg   <= s_tdata;
        end
        if (fire) begin
            out_reg <= res_out;
        end
    end

    // The head byte is read at the next read index, so it is ready when
    // the following item arrives.
    utb_ring_mem #(
        .DEPTH  (BUF_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (in_data_reg),
        .rd_addr (rd_idx_next),
        .rd_data (head_byte)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_idx_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg != '0) |-> (WIDE_W'(wr_idx_reg) < len_w && WIDE_W'(rd_idx_reg) < len_w))
        else $error("ring index outside buffer length");

    a_done_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.send_done) |-> (out_reg.tx_valid && !out_reg.tx_request))
        else $error("send_done without a final pop");

    a_accept_requests: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.accepted) |-> (out_reg.tx_request && !out_reg.tx_valid))
        else $error("accepted push without transmit request");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_reg.tx_valid) |-> (out_reg.tx_byte == '0))
        else $error("tx_byte set without a pop");

    a_pop_empty_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_action_reg == ACT_TX_READY && wr_idx_reg == rd_idx_reg)
            |=> $stable(rd_idx_reg) || $past(cfg_fire))
        else $error("read index moved on an empty ring");

endmodule

`default_nettype wire

// File: src/utb_ring_mem.sv
// Byte store of the transmit ring buffer: one write port and one registered
// read port with write-to-read bypass. Depends on utb_pkg.
`default_nettype none

module utb_ring_mem
    import utb_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_q_reg;
    logic [BYTE_W-1:0] byp_data_reg;
    logic              byp_reg;
    logic              byp_next;

    assign byp_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // The array read returns the old contents when the same slot is written
    // in that cycle, so the new byte is forwarded instead.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= byp_next;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

`default_nettype wire

// File: test/tb_uart_tx_ring_buffer.sv
// Self-checking testbench for the transmit ring buffer.
// A queue-fed driver and a clocked monitor check every result against a local ring model.
// Depends on utb_pkg and the uart_tx_ring_buffer RTL.
module tb_uart_tx_ring_buffer;
    import utb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 4096;
    localparam int STALL_LIMIT = 1000;
    localparam action_t ACT_UNUSED = 2'd3;

    typedef struct packed {
        action_t           act;
        logic [BYTE_W-1:0] data;
    } ring_op_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [ACTION_W-1:0]  s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;

    uart_tx_ring_buffer #(.BUF_DEPTH(RING_DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Local copy of the ring state and registers.
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    int unsigned       ring_len;
    int unsigned       ring_wr;
    int unsigned       ring_rd;
    bit                rs485_on;
    bit                drive_q;
    bit                request_q;

    ring_op_t    pending_items[$];
    result_t     expected_status[$];
    int          error_count = 0;
    bit          bursts_on = 1'b1;
    bit          drain_hold = 1'b0;
    int          s_gap = 0;
    int          m_stall = 0;
    int          quiet_cycles = 0;

    function automatic int unsigned ring_next(int unsigned idx);
        int unsigned n;
        n = idx + 1;
        if (n >= ring_len) begin
            n = 0;
        end
        return n;
    endfunction

    function automatic int unsigned ring_fill();
        if (ring_rd <= ring_wr) begin
            return ring_wr - ring_rd;
        end
        return ring_len + ring_wr - ring_rd;
    endfunction

    function automatic result_t ring_apply(ring_op_t op);
        result_t     r;
        int unsigned n;
        int unsigned fill;
        r = '0;
        case (op.act)
            ACT_PUSH: begin
                if (ring_len != 0) begin
                    n = ring_next(ring_wr);
                    if (n != ring_rd) begin
                        ring_mem[ring_wr] = op.data;
                        ring_wr = n;
                        r.accepted = 1'b1;
                    end
                    request_q = 1'b1;
                end
            end
            ACT_TX_READY: begin
                if (ring_wr == ring_rd) begin
                    request_q = 1'b0;
                end else begin
                    if (rs485_on) begin
                        drive_q = 1'b1;
                    end
                    r.tx_byte = ring_mem[ring_rd];
                    r.tx_valid = 1'b1;
                    ring_rd = ring_next(ring_rd);
                    if (ring_wr == ring_rd) begin
                        if (rs485_on) begin
                            drive_q = 1'b0;
                        end
                        request_q = 1'b0;
                        r.send_done = 1'b1;
                    end
                end
            end
            ACT_CLEAR: begin
                if (ring_len != 0) begin
                    ring_wr = 0;
                    ring_rd = 0;
                end
            end
            default: ;
        endcase
        fill = ring_fill();
        r.pending_count = PEND_W'(fill);
        r.free_count = LEN_W'(ring_len - fill);
        r.line_drive = drive_q;
        r.tx_request = request_q;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // Input driver: takes items from pending_items and predicts on each transaction.
    always @(posedge aclk) begin : s_driver
        bit next_valid;
        bit busy;
        ring_op_t op;
        if (aresetn) begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                op.act = s_tuser;
                op.data = s_tdata;
                expected_status.push_back(ring_apply(op));
                busy = 1'b0;
            end
            if (!busy) begin
                next_valid = 1'b0;
                if (drain_hold && expected_status.size() == 0) begin
                    drain_hold = 1'b0;
                end
                if (s_gap > 0) begin
                    s_gap--;
                end else if (!drain_hold && pending_items.size() > 0) begin
                    if (bursts_on && $urandom_range(0, 7) == 0) begin
                        s_gap = $urandom_range(0, 3);
                    end else if (bursts_on && $urandom_range(0, 199) == 0) begin
                        // Hold off until the block has returned everything.
                        drain_hold = 1'b1;
                    end else begin
                        op = pending_items.pop_front();
                        s_tuser <= op.act;
                        s_tdata <= op.data;
                        next_valid = 1'b1;
                    end
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin : m_monitor
        result_t got;
        result_t want;
        bit next_ready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_tdata), '0);
                end else begin
                    want = expected_status.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted),
                                        32'(want.accepted));
                    if (got.tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", 32'(got.tx_valid),
                                        32'(want.tx_valid));
                    if (got.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", 32'(got.tx_byte),
                                        32'(want.tx_byte));
                    if (got.pending_count !== want.pending_count)
                        report_mismatch("pending_count", 32'(got.pending_count),
                                        32'(want.pending_count));
                    if (got.free_count !== want.free_count)
                        report_mismatch("free_count", 32'(got.free_count),
                                        32'(want.free_count));
                    if (got.send_done !== want.send_done)
                        report_mismatch("send_done", 32'(got.send_done),
                                        32'(want.send_done));
                    if (got.line_drive !== want.line_drive)
                        report_mismatch("line_drive", 32'(got.line_drive),
                                        32'(want.line_drive));
                    if (got.tx_request !== want.tx_request)
                        report_mismatch("tx_request", 32'(got.tx_request),
                                        32'(want.tx_request));
                    if (got.pad !== want.pad)
                        report_mismatch("pad", 32'(got.pad), 32'(want.pad));
                end
            end
            next_ready = 1'b0;
            if (m_stall > 0) begin
                m_stall--;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                m_stall = $urandom_range(0, 3);
            end else begin
                next_ready = 1'b1;
            end
            m_tready <= next_ready;
        end
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("uart_tx_ring_buffer verification failed");
                    $finish;
                end
            end
        end
    end

    // Sampled on the falling edge so that the driver and monitor have settled.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BUFFER_LENGTH) begin
            ring_len = (value > RING_DEPTH) ? 0 : 32'(value);
            ring_wr = 0;
            ring_rd = 0;
        end else begin
            rs485_on = value[0];
        end
        @(posedge aclk);
    endtask

    task automatic reconfigure(logic [LEN_W-1:0] len, bit mode);
        wait_idle();
        write_reg(CFG_BUFFER_LENGTH, len);
        write_reg(CFG_RS485_MODE, LEN_W'(mode));
    endtask

    task automatic add_op(action_t act, logic [BYTE_W-1:0] data);
        ring_op_t op;
        op.act = act;
        op.data = data;
        pending_items.push_back(op);
    endtask

    // Mostly fill-then-drain bursts sized to the ring, with clears and odd codes mixed in.
    task automatic add_traffic(int count, int unsigned len);
        int issued;
        int burst;
        int max_burst;
        int cap;
        int k;
        issued = 0;
        max_burst = (len >= 1024) ? 300 : ((len + 3 > 64) ? 64 : len + 3);
        while (issued < count) begin
            k = $urandom_range(0, 99);
            if (k < 5) begin
                add_op(ACT_CLEAR, BYTE_W'($urandom_range(0, 255)));
                issued++;
            end else if (k < 8) begin
                add_op(ACT_UNUSED, BYTE_W'($urandom_range(0, 255)));
                issued++;
            end else if (k < 14) begin
                add_op(action_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
                issued++;
            end else begin
                // Keep the burst within what is left of this phase.
                cap = (count - issued + 1) / 2;
                if (cap > max_burst) begin
                    cap = max_burst;
                end
                burst = $urandom_range(1, cap);
                repeat (burst) add_op(ACT_PUSH, BYTE_W'($urandom_range(0, 255)));
                issued += burst;
                burst = $urandom_range(1, burst + 2);
                repeat (burst) add_op(ACT_TX_READY, BYTE_W'($urandom_range(0, 255)));
                issued += burst;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        ring_len = 0;
        ring_wr = 0;
        ring_rd = 0;
        rs485_on = 1'b0;
        drive_q = 1'b0;
        request_q = 1'b0;
        @(posedge aclk);

        // Disabled buffer straight out of reset.
        add_op(ACT_PUSH, 8'h00);
        add_op(ACT_TX_READY, 8'hFF);
        add_op(ACT_CLEAR, 8'h00);
        add_op(ACT_UNUSED, 8'hFF);

        // A ring of one slot refuses every push.
        reconfigure(13'd1, 1'b0);
        add_op(ACT_PUSH, 8'hFF);
        add_op(ACT_TX_READY, 8'h00);

        // Fill past full, drain to completion, then pop on an empty ring.
        reconfigure(13'd4, 1'b1);
        add_op(ACT_PUSH, 8'hFF);
        add_op(ACT_PUSH, 8'h00);
        add_op(ACT_PUSH, 8'hA5);
        add_op(ACT_PUSH, 8'h3C);
        add_op(ACT_TX_READY, 8'h00);
        add_op(ACT_TX_READY, 8'h00);
        add_op(ACT_TX_READY, 8'h00);
        add_op(ACT_TX_READY, 8'h00);
        add_op(ACT_PUSH, 8'h5A);
        add_op(ACT_CLEAR, 8'h00);
        add_op(ACT_TX_READY, 8'h00);
        add_op(ACT_UNUSED, 8'h00);

        // Lengths above the depth disable the buffer.
        reconfigure(13'd4097, 1'b0);
        add_op(ACT_PUSH, 8'h11);
        reconfigure(13'h1FFF, 1'b1);
        add_op(ACT_PUSH, 8'h22);
        add_op(ACT_CLEAR, 8'h00);

        reconfigure(13'd2, 1'b0);
        add_traffic(100, 2);
        reconfigure(13'd3, 1'b1);
        add_traffic(100, 3);
        reconfigure(13'd16, 1'b0);
        add_traffic(100, 16);
        reconfigure(13'd4096, 1'b1);
        add_traffic(150, 4096);
        reconfigure(13'd1, 1'b1);
        add_traffic(40, 1);
        reconfigure(13'd0, 1'b1);
        add_traffic(40, 0);
        begin : rand_len_phase
            int unsigned len;
            len = $urandom_range(5, 40);
            reconfigure(LEN_W'(len), 1'($urandom_range(0, 1)));
            add_traffic(150, len);
            len = $urandom_range(41, 4096);
            reconfigure(LEN_W'(len), 1'($urandom_range(0, 1)));
            add_traffic(120, len);
        end

        // Final stretch runs without idling on either side.
        reconfigure(13'd8, 1'b1);
        bursts_on = 1'b0;
        add_traffic(100, 8);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("uart_tx_ring_buffer verification clean");
        end else begin
            $display("uart_tx_ring_buffer verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/utb_pkg.sv
src/utb_ring_mem.sv
src/uart_tx_ring_buffer.sv
test/tb_uart_tx_ring_buffer.sv
